FILE: src/response_ratio_job_scheduler_defines.svh
// Assertion macros shared by the scheduler modules.
`ifndef RESPONSE_RATIO_JOB_SCHEDULER_DEFINES_SVH
`define RESPONSE_RATIO_JOB_SCHEDULER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define RRS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// Next-cycle implication, off during reset.
`define RRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

FILE: src/rrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared codes, fixed field widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rrs_pkg;

   localparam int OUT_ID_BITS = 8;
   localparam int OUT_BURST_BITS = 16;
   localparam int WAIT_BITS = 16;
   localparam int TIME_BITS = 32;
   localparam int TAT_BITS = 17;
   localparam int PRIO_BITS = 17;
   localparam int IN_ID_BITS = 8;
   localparam int IN_BURST_BITS = 16;

   localparam logic [WAIT_BITS-1:0] WAIT_MAX = '1;
   localparam logic [TAT_BITS-1:0] TAT_MAX = '1;

   localparam logic ACT_ARRIVE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_ZERO_BURST = 2'd2;
   localparam logic [1:0] ST_TICK_DONE = 2'd3;

   typedef struct packed {
      logic arrive;      // enter a job and load its response
      logic quiet_tick;  // tick with nothing ready or running
      logic sort_en;     // one odd-even transposition pass
      logic sort_odd;    // pass pairs (1,2),(3,4)... when set
      logic exec;        // dispatch, serve, age, load response
   } cmd_type;

   typedef struct packed {
      logic busy;        // table not empty or slot occupied
   } sts_type;

endpackage

FILE: src/response_ratio_job_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// response_ratio_job_scheduler
// Non-preemptive highest-response-ratio-next scheduler with one running slot.
// ----------------------------------------------------------------------------
// An arrive transaction and a tick with nothing ready or running are each
// handled in the accept cycle. A tick with work runs the accept cycle, ENTRIES
// odd-even transposition passes over the ready table (one pass per cycle), and
// a final step that dispatches, serves, ages the table and loads the response.
// One transaction is in flight at a time; a response held in the output
// register does not block the next accept once it is being taken.
module response_ratio_job_scheduler #(
   parameter int ENTRIES = 16,
   parameter int ID_BITS = 8,
   parameter int BURST_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // job_id[7:0], burst_length[23:8]
   input  logic         req_tuser,   // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // dispatched[0], cpu_busy[1], running_id[9:2], completed[10], done_id[18:11],
   // done_arrival[50:19], done_burst[66:51], done_wait[82:67],
   // done_turnaround[99:83], zero[103:100]
   output logic [103:0] rsp_tdata,
   output logic [1:0]   rsp_tuser    // status
);
   import rrs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rrs_ctrl #(
      .ENTRIES(ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rrs_datapath #(
      .ENTRIES   (ENTRIES),
      .ID_BITS   (ID_BITS),
      .BURST_BITS(BURST_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_job_id         (req_tdata[7:0]),
      .req_burst_length   (req_tdata[23:8]),
      .rsp_status         (rsp_tuser),
      .rsp_dispatched     (rsp_tdata[0]),
      .rsp_cpu_busy       (rsp_tdata[1]),
      .rsp_running_id     (rsp_tdata[9:2]),
      .rsp_completed      (rsp_tdata[10]),
      .rsp_done_id        (rsp_tdata[18:11]),
      .rsp_done_arrival   (rsp_tdata[50:19]),
      .rsp_done_burst     (rsp_tdata[66:51]),
      .rsp_done_wait      (rsp_tdata[82:67]),
      .rsp_done_turnaround(rsp_tdata[99:83])
   );

   assign rsp_tdata[103:100] = '0;

endmodule

FILE: src/rrs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_ctrl
// Sequencer: accepts transactions, steps the sort passes, owns response valid.
// ----------------------------------------------------------------------------
`include "response_ratio_job_scheduler_defines.svh"
module rrs_ctrl #(
   parameter int ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_action,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  rrs_pkg::sts_type sts,
   output rrs_pkg::cmd_type cmd
);
   import rrs_pkg::*;

   localparam int PASS_BITS = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SORT = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [PASS_BITS-1:0] pass_ff, pass_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_free;
   logic                 accept;
   logic                 load;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action == ACT_ARRIVE) begin
                  cmd.arrive = 1'b1;
               end else if (!sts.busy) begin
                  cmd.quiet_tick = 1'b1;
               end else begin
                  state_in = S_SORT;
                  pass_in  = '0;
               end
            end
         end
         S_SORT: begin
            cmd.sort_en  = 1'b1;
            cmd.sort_odd = pass_ff[0];
            pass_in      = pass_ff + 1'b1;
            if (pass_ff == PASS_BITS'(ENTRIES - 1)) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign load = cmd.arrive || cmd.quiet_tick || cmd.exec;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `RRS_ASSERT_NEXT(a_busy_tick_sorts, clock, reset, accept && req_action == ACT_TICK && sts.busy, state_ff == S_SORT)
   `RRS_ASSERT_NOW(a_load_needs_room, clock, reset, load, out_free)

endmodule

FILE: src/rrs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_datapath
// Ready table cells with sort network, running slot, time and response register.
// ----------------------------------------------------------------------------
`include "response_ratio_job_scheduler_defines.svh"
module rrs_datapath #(
   parameter int ENTRIES = 16,
   parameter int ID_BITS = 8,
   parameter int BURST_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rrs_pkg::cmd_type                     cmd,
   output rrs_pkg::sts_type                     sts,
   input  logic [rrs_pkg::IN_ID_BITS-1:0]       req_job_id,
   input  logic [rrs_pkg::IN_BURST_BITS-1:0]    req_burst_length,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_dispatched,
   output logic                                 rsp_cpu_busy,
   output logic [rrs_pkg::OUT_ID_BITS-1:0]      rsp_running_id,
   output logic                                 rsp_completed,
   output logic [rrs_pkg::OUT_ID_BITS-1:0]      rsp_done_id,
   output logic [rrs_pkg::TIME_BITS-1:0]        rsp_done_arrival,
   output logic [rrs_pkg::OUT_BURST_BITS-1:0]   rsp_done_burst,
   output logic [rrs_pkg::WAIT_BITS-1:0]        rsp_done_wait,
   output logic [rrs_pkg::TAT_BITS-1:0]         rsp_done_turnaround
);
   import rrs_pkg::*;

   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam int SUM_BITS = ((BURST_BITS > WAIT_BITS) ? BURST_BITS : WAIT_BITS) + 1;

   typedef struct packed {
      logic [ID_BITS-1:0]    id;
      logic [BURST_BITS-1:0] burst;
      logic [WAIT_BITS-1:0]  wait_t;
      logic [WAIT_BITS-1:0]  rem;
      logic [WAIT_BITS-1:0]  quo;
      logic                  aged;
      logic [TIME_BITS-1:0]  arrival;
   } entry_type;

   entry_type             tbl_ff [ENTRIES];
   entry_type             tbl_in [ENTRIES];
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic                  slot_valid_ff, slot_valid_in;
   entry_type             slot_ff, slot_in;
   logic [BURST_BITS-1:0] slot_rem_ff, slot_rem_in;

   logic [1:0]            status_ff, status_in;
   logic                  disp_ff, disp_in;
   logic                  cpu_ff, cpu_in;
   logic [OUT_ID_BITS-1:0] run_id_ff, run_id_in;
   logic                  compl_ff, compl_in;
   logic [OUT_ID_BITS-1:0] done_id_ff, done_id_in;
   logic [TIME_BITS-1:0]  done_arr_ff, done_arr_in;
   logic [OUT_BURST_BITS-1:0] done_burst_ff, done_burst_in;
   logic [WAIT_BITS-1:0]  done_wait_ff, done_wait_in;
   logic [TAT_BITS-1:0]   done_tat_ff, done_tat_in;

   logic [BURST_BITS-1:0] new_burst;
   logic                  dispatch;
   entry_type             serve;
   logic [BURST_BITS-1:0] serve_rem;
   logic [SUM_BITS-1:0]   tat_sum;
   logic                  finishing;

   function automatic logic [PRIO_BITS-1:0] prio_of(entry_type e);
      logic [PRIO_BITS-1:0] p;
      p = e.aged ? (PRIO_BITS'(e.quo) + 1'b1) : '0;
      return p;
   endfunction

   // one wait tick; quotient and remainder of wait/burst tracked incrementally
   function automatic entry_type age(entry_type e);
      entry_type r;
      r = e;
      r.aged = 1'b1;
      if (e.wait_t != WAIT_MAX) begin
         r.wait_t = e.wait_t + 1'b1;
         if ((SUM_BITS'(e.rem) + 1'b1) == SUM_BITS'(e.burst)) begin
            r.rem = '0;
            r.quo = e.quo + 1'b1;
         end else begin
            r.rem = e.rem + 1'b1;
         end
      end
      return r;
   endfunction

   assign sts.busy  = (count_ff != '0) || slot_valid_ff;
   assign new_burst = BURST_BITS'(req_burst_length);
   assign dispatch  = !slot_valid_ff && (count_ff != '0);
   assign serve     = dispatch ? tbl_ff[0] : slot_ff;
   assign serve_rem = dispatch ? tbl_ff[0].burst : slot_rem_ff;
   assign finishing = serve_rem <= BURST_BITS'(1);
   assign tat_sum   = SUM_BITS'(serve.burst) + SUM_BITS'(serve.wait_t);

   always_comb begin
      tbl_in        = tbl_ff;
      count_in      = count_ff;
      time_in       = time_ff;
      slot_valid_in = slot_valid_ff;
      slot_in       = slot_ff;
      slot_rem_in   = slot_rem_ff;
      status_in     = status_ff;
      disp_in       = disp_ff;
      cpu_in        = cpu_ff;
      run_id_in     = run_id_ff;
      compl_in      = compl_ff;
      done_id_in    = done_id_ff;
      done_arr_in   = done_arr_ff;
      done_burst_in = done_burst_ff;
      done_wait_in  = done_wait_ff;
      done_tat_in   = done_tat_ff;

      if (cmd.arrive || cmd.quiet_tick || cmd.exec) begin
         disp_in       = 1'b0;
         cpu_in        = 1'b0;
         run_id_in     = '0;
         compl_in      = 1'b0;
         done_id_in    = '0;
         done_arr_in   = '0;
         done_burst_in = '0;
         done_wait_in  = '0;
         done_tat_in   = '0;
      end

      if (cmd.arrive) begin
         if (new_burst == '0) begin
            status_in = ST_ZERO_BURST;
         end else if (count_ff == CNT_BITS'(ENTRIES)) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_ACCEPTED;
            for (int i = 0; i < ENTRIES; i++) begin
               if (CNT_BITS'(i) == count_ff) begin
                  tbl_in[i].id      = ID_BITS'(req_job_id);
                  tbl_in[i].burst   = new_burst;
                  tbl_in[i].wait_t  = '0;
                  tbl_in[i].rem     = '0;
                  tbl_in[i].quo     = '0;
                  tbl_in[i].aged    = 1'b0;
                  tbl_in[i].arrival = time_ff;
               end
            end
            count_in = count_ff + 1'b1;
         end
      end

      if (cmd.quiet_tick) begin
         status_in = ST_TICK_DONE;
         time_in   = time_ff + 1'b1;
      end

      // stable: swap only on strictly lower priority ahead
      if (cmd.sort_en) begin
         for (int j = 0; j < ENTRIES - 1; j++) begin
            if ((j % 2) == int'(cmd.sort_odd) && CNT_BITS'(j + 1) < count_ff
                && prio_of(tbl_ff[j]) < prio_of(tbl_ff[j + 1])) begin
               tbl_in[j]     = tbl_ff[j + 1];
               tbl_in[j + 1] = tbl_ff[j];
            end
         end
      end

      if (cmd.exec) begin
         status_in = ST_TICK_DONE;
         time_in   = time_ff + 1'b1;
         disp_in   = dispatch;
         cpu_in    = 1'b1;
         run_id_in = OUT_ID_BITS'(serve.id);
         // pop the head on dispatch, age everything left
         for (int i = 0; i < ENTRIES; i++) begin
            if (dispatch && i < ENTRIES - 1) begin
               tbl_in[i] = age(tbl_ff[i + 1]);
            end else begin
               tbl_in[i] = age(tbl_ff[i]);
            end
         end
         if (dispatch) begin
            count_in = count_ff - 1'b1;
         end
         if (finishing) begin
            compl_in      = 1'b1;
            done_id_in    = OUT_ID_BITS'(serve.id);
            done_arr_in   = serve.arrival;
            done_burst_in = OUT_BURST_BITS'(serve.burst);
            done_wait_in  = serve.wait_t;
            done_tat_in   = (tat_sum > SUM_BITS'(TAT_MAX)) ? TAT_MAX : TAT_BITS'(tat_sum);
            slot_valid_in = 1'b0;
         end else begin
            slot_valid_in = 1'b1;
            slot_in       = serve;
            slot_rem_in   = serve_rem - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         time_ff       <= '0;
         slot_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         time_ff       <= time_in;
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tbl_ff        <= tbl_in;
      slot_ff       <= slot_in;
      slot_rem_ff   <= slot_rem_in;
      status_ff     <= status_in;
      disp_ff       <= disp_in;
      cpu_ff        <= cpu_in;
      run_id_ff     <= run_id_in;
      compl_ff      <= compl_in;
      done_id_ff    <= done_id_in;
      done_arr_ff   <= done_arr_in;
      done_burst_ff <= done_burst_in;
      done_wait_ff  <= done_wait_in;
      done_tat_ff   <= done_tat_in;
   end

   assign rsp_status          = status_ff;
   assign rsp_dispatched      = disp_ff;
   assign rsp_cpu_busy        = cpu_ff;
   assign rsp_running_id      = run_id_ff;
   assign rsp_completed       = compl_ff;
   assign rsp_done_id         = done_id_ff;
   assign rsp_done_arrival    = done_arr_ff;
   assign rsp_done_burst      = done_burst_ff;
   assign rsp_done_wait       = done_wait_ff;
   assign rsp_done_turnaround = done_tat_ff;

   `RRS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(ENTRIES))
   `RRS_ASSERT_NEXT(a_finish_frees_slot, clock, reset, cmd.exec && finishing, !slot_valid_ff)

endmodule

FILE: tb/sv/tb_response_ratio_job_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_response_ratio_job_scheduler
// Stream-level test of the response-ratio scheduler: a directed burst of
// arrivals and ticks, then random job streams, checked against a local
// model of the ready table, the running slot and the time counter.
// ----------------------------------------------------------------------------
module tb_response_ratio_job_scheduler;
   import rrs_pkg::*;

   localparam int ENTRIES = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic        action;
      logic [7:0]  job_id;
      logic [15:0] burst;
   } job_req_t;

   typedef struct packed {
      logic [1:0]   status;
      logic [103:0] data;
   } sched_rsp_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   response_ratio_job_scheduler #(.ENTRIES(ENTRIES)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   // scheduler model state
   logic [7:0]  tbl_id [ENTRIES];
   logic [15:0] tbl_burst [ENTRIES];
   logic [15:0] tbl_wait [ENTRIES];
   logic [16:0] tbl_prio [ENTRIES];
   logic [31:0] tbl_arrival [ENTRIES];
   int          tbl_count = 0;
   logic [31:0] sched_time = '0;
   logic        cpu_valid = 1'b0;
   logic [7:0]  cpu_id = '0;
   logic [15:0] cpu_left = '0, cpu_burst = '0, cpu_wait = '0;
   logic [31:0] cpu_arrival = '0;

   job_req_t   pending_jobs[$];
   sched_rsp_t expected_rsps[$];
   int mismatches = 0, n_ticks = 0, n_done = 0, n_full = 0;
   int send_idle_pct = 0, recv_stall_pct = 0;
   int quiet_cycles = 0;
   bit stim_done = 0;

   // append to the tail of the stimulus and scoreboard queues
   function automatic void add_job(job_req_t j);
      pending_jobs.insert(pending_jobs.size(), j);
   endfunction

   function automatic void add_expected(sched_rsp_t r);
      expected_rsps.insert(expected_rsps.size(), r);
   endfunction

   function automatic void swap_rows(int a, int b);
      logic [7:0] t8; logic [15:0] t16; logic [16:0] t17; logic [31:0] t32;
      t8 = tbl_id[a]; tbl_id[a] = tbl_id[b]; tbl_id[b] = t8;
      t16 = tbl_burst[a]; tbl_burst[a] = tbl_burst[b]; tbl_burst[b] = t16;
      t16 = tbl_wait[a]; tbl_wait[a] = tbl_wait[b]; tbl_wait[b] = t16;
      t17 = tbl_prio[a]; tbl_prio[a] = tbl_prio[b]; tbl_prio[b] = t17;
      t32 = tbl_arrival[a]; tbl_arrival[a] = tbl_arrival[b]; tbl_arrival[b] = t32;
   endfunction

   function automatic sched_rsp_t schedule_step(job_req_t j);
      sched_rsp_t r;
      logic [17:0] tat;
      r = '0;
      if (j.action == ACT_ARRIVE) begin
         if (j.burst == 0) begin
            r.status = ST_ZERO_BURST;
         end else if (tbl_count >= ENTRIES) begin
            r.status = ST_FULL;
            n_full++;
         end else begin
            tbl_id[tbl_count] = j.job_id;
            tbl_burst[tbl_count] = j.burst;
            tbl_wait[tbl_count] = '0;
            tbl_prio[tbl_count] = '0;
            tbl_arrival[tbl_count] = sched_time;
            tbl_count++;
            r.status = ST_ACCEPTED;
         end
         return r;
      end
      r.status = ST_TICK_DONE;
      n_ticks++;
      if (tbl_count > 0 || cpu_valid) begin
         for (int i = 0; i < tbl_count; i++)
            for (int k = 0; k + 1 < tbl_count - i; k++)
               if (tbl_prio[k] < tbl_prio[k+1]) swap_rows(k, k + 1);
         if (!cpu_valid && tbl_count > 0) begin
            cpu_valid = 1'b1;
            cpu_id = tbl_id[0];
            cpu_left = tbl_burst[0];
            cpu_burst = tbl_burst[0];
            cpu_wait = tbl_wait[0];
            cpu_arrival = tbl_arrival[0];
            for (int i = 0; i + 1 < tbl_count; i++) swap_rows(i, i + 1);
            tbl_count--;
            r.data[0] = 1'b1;
         end
         r.data[1] = 1'b1;
         r.data[9:2] = cpu_id;
         if (cpu_left <= 1) begin
            n_done++;
            r.data[10] = 1'b1;
            r.data[18:11] = cpu_id;
            r.data[50:19] = cpu_arrival;
            r.data[66:51] = cpu_burst;
            r.data[82:67] = cpu_wait;
            tat = {2'b0, cpu_burst} + {2'b0, cpu_wait};
            r.data[99:83] = (tat > 18'h1FFFF) ? TAT_MAX : tat[16:0];
            cpu_valid = 1'b0;
            cpu_id = '0; cpu_left = '0; cpu_burst = '0; cpu_wait = '0; cpu_arrival = '0;
         end else begin
            cpu_left--;
         end
         for (int i = 0; i < tbl_count; i++) begin
            if (tbl_wait[i] != WAIT_MAX) tbl_wait[i]++;
            tbl_prio[i] = 17'(1 + tbl_wait[i] / tbl_burst[i]);
         end
      end
      sched_time++;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (req_tvalid && req_tready) add_expected(schedule_step(
               job_req_t'{req_tuser, req_tdata[7:0], req_tdata[23:8]}));
            if (pending_jobs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tuser <= pending_jobs[0].action;
               req_tdata <= {pending_jobs[0].burst, pending_jobs[0].job_id};
               void'(pending_jobs.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      sched_rsp_t want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h/%h", rsp_tuser, rsp_tdata);
            end else begin
               want = expected_rsps.pop_front();
               if (want.status !== rsp_tuser || want.data !== rsp_tdata) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp status %0d data %h, got status %0d data %h",
                              want.status, want.data, rsp_tuser, rsp_tdata);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d responses outstanding", expected_rsps.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic job_req_t mk_arrive(logic [7:0] id, logic [15:0] b);
      return job_req_t'{ACT_ARRIVE, id, b};
   endfunction

   function automatic job_req_t mk_tick();
      return job_req_t'{ACT_TICK, 8'($urandom), 16'($urandom)};
   endfunction

   task automatic wait_drained();
      while (pending_jobs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   task automatic random_phase(int count);
      int mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(99);
         if (mode < 40) add_job(mk_tick());
         else if (mode < 45) add_job(mk_arrive(8'($urandom), '0));
         else if (mode < 50) add_job(mk_arrive(8'($urandom), 16'($urandom)));
         else if (mode < 53) add_job(mk_arrive(8'($urandom), 16'hFFFF));
         else add_job(mk_arrive(8'($urandom), 16'($urandom_range(1, 6))));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: idle tick, zero burst, extremes, fill past full, drain
      add_job(mk_tick());
      add_job(mk_arrive(8'hFF, 16'h0000));
      add_job(mk_arrive(8'h00, 16'h0001));
      add_job(mk_arrive(8'hFF, 16'hFFFF));
      for (int i = 0; i < 15; i++) add_job(mk_arrive(8'(i + 16), 16'(i % 3 + 1)));
      add_job(mk_arrive(8'hAA, 16'h0000));
      for (int i = 0; i < 5; i++) add_job(mk_tick());
      wait_drained();
      send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(300); wait_drained();
      send_idle_pct = 76; recv_stall_pct = 0;  random_phase(300); wait_drained();
      send_idle_pct = 0;  recv_stall_pct = 76; random_phase(300); wait_drained();
      send_idle_pct = 25; recv_stall_pct = 25; random_phase(300); wait_drained();
      repeat (3 * ENTRIES) @(posedge clock);
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      $display("covered %0d ticks, %0d completions, %0d full-table rejections",
               n_ticks, n_done, n_full);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
